FILE: rtl/m3inv_pkg.sv
package m3inv_pkg;

  localparam int DATA_W        = 32;
  localparam int N_ELEM        = 9;
  localparam int FRAC_BITS_DEF = 16;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int COF_W         = PROD_W + 1;
  localparam int PART_W        = COF_W;
  localparam int DET_W         = DATA_W + COF_W + 2;
  localparam int QUO_W         = DATA_W;
  localparam int QUEUE_DEPTH   = 4;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [DET_W-1:0]  det_t;

  typedef struct packed {
    cof_t [N_ELEM-1:0] cof;
    det_t              det;
    logic              singular;
  } job_t;

endpackage

FILE: rtl/m3i_in_if.sv
interface m3i_in_if;
  import m3inv_pkg::*;

  logic  valid;
  logic  ready;
  data_t a0, a1, a2, a3, a4, a5, a6, a7, a8;

  modport source (output valid, a0, a1, a2, a3, a4, a5, a6, a7, a8, input ready);
  modport sink   (input valid, a0, a1, a2, a3, a4, a5, a6, a7, a8, output ready);
endinterface

FILE: rtl/m3i_out_if.sv
interface m3i_out_if;
  import m3inv_pkg::*;

  logic  valid;
  logic  ready;
  data_t r0, r1, r2, r3, r4, r5, r6, r7, r8;
  logic  singular;
  logic  overflow;

  modport source (output valid, r0, r1, r2, r3, r4, r5, r6, r7, r8, singular, overflow,
                  input ready);
  modport sink   (input valid, r0, r1, r2, r3, r4, r5, r6, r7, r8, singular, overflow,
                  output ready);
endinterface

FILE: rtl/m3i_front.sv
module m3i_front (
  input  logic              clk,
  input  logic              rst,
  m3i_in_if.sink            req,
  input  logic              job_ready,
  output logic              job_valid,
  output m3inv_pkg::job_t   job
);
  import m3inv_pkg::*;

  // cofactor i = a[PX]*a[PY] - a[NX]*a[NY]
  localparam int PX [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int PY [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int NX [N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int NY [N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  data_t                    a [N_ELEM];
  logic                     en;
  logic                     s1_valid, s2_valid, s3_valid, s4_valid;
  logic signed [PROD_W-1:0] s1_pp [N_ELEM];
  logic signed [PROD_W-1:0] s1_pn [N_ELEM];
  data_t                    s1_a [3];
  data_t                    s2_a [3];
  cof_t                     s2_cof [N_ELEM];
  cof_t                     s3_cof [N_ELEM];
  logic signed [PART_W-1:0] s3_hi [3];
  logic signed [PART_W-1:0] s3_lo [3];
  cof_t                     s4_cof [N_ELEM];
  det_t                     s4_det;
  det_t                     hsum, lsum;

  assign a = '{req.a0, req.a1, req.a2, req.a3, req.a4, req.a5, req.a6, req.a7, req.a8};

  // Hold the whole pipe when the queue cannot take the oldest item.
  assign en        = !(s4_valid && !job_ready);
  assign req.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= req.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_comb begin
    hsum = '0;
    lsum = '0;
    for (int j = 0; j < 3; j++) begin
      hsum = hsum + {{(DET_W-PART_W){s3_hi[j][PART_W-1]}}, s3_hi[j]};
      lsum = lsum + {{(DET_W-PART_W){s3_lo[j][PART_W-1]}}, s3_lo[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_ELEM; i++) begin
        s1_pp[i] <= PROD_W'(a[PX[i]]) * PROD_W'(a[PY[i]]);
        s1_pn[i] <= PROD_W'(a[NX[i]]) * PROD_W'(a[NY[i]]);
        s2_cof[i] <= {s1_pp[i][PROD_W-1], s1_pp[i]} - {s1_pn[i][PROD_W-1], s1_pn[i]};
        s3_cof[i] <= s2_cof[i];
        s4_cof[i] <= s3_cof[i];
      end
      for (int j = 0; j < 3; j++) begin
        s1_a[j]  <= a[j];
        s2_a[j]  <= s1_a[j];
        // split the cofactor: signed upper part, unsigned lower word
        s3_hi[j] <= PART_W'(s2_a[j]) * PART_W'($signed(s2_cof[j*3][COF_W-1:DATA_W]));
        s3_lo[j] <= PART_W'(s2_a[j]) * $signed({1'b0, s2_cof[j*3][DATA_W-1:0]});
      end
      s4_det <= (hsum <<< DATA_W) + lsum;
    end
  end

  always_comb begin
    job_valid    = s4_valid;
    job.det      = s4_det;
    job.singular = (s4_det == '0);
    for (int i = 0; i < N_ELEM; i++) begin
      job.cof[i] = s4_cof[i];
    end
  end

endmodule

FILE: rtl/m3i_queue.sv
module m3i_queue #(
  parameter int DEPTH = m3inv_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  m3inv_pkg::job_t   push_job,
  output logic              not_full,
  input  logic              pop,
  output logic              not_empty,
  output m3inv_pkg::job_t   head
);
  import m3inv_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign not_full  = (count != CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_job;
    end
  end

endmodule

FILE: rtl/m3i_back.sv
module m3i_back #(
  parameter int FRAC_BITS = m3inv_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  m3inv_pkg::job_t   job,
  output logic              job_pop,
  m3i_out_if.source         rsp
);
  import m3inv_pkg::*;

  localparam int NUM_W = COF_W + 2 * FRAC_BITS;
  localparam int REM_W = (NUM_W > DET_W + QUO_W) ? NUM_W : DET_W + QUO_W;
  localparam int NST   = QUO_W + 1;

  logic                en;
  logic                b0_valid;
  logic [COF_W-1:0]    b0_cmag [N_ELEM];
  logic                b0_neg  [N_ELEM];
  logic [DET_W-1:0]    b0_dmag;
  logic                b0_sing;

  logic [REM_W-1:0]    rem  [NST][N_ELEM];
  logic [QUO_W-1:0]    quo  [NST][N_ELEM];
  logic                neg  [NST][N_ELEM];
  logic                ovf  [NST][N_ELEM];
  logic [DET_W-1:0]    dmag [NST];
  logic                sing [NST];
  logic                vld  [NST];

  logic                o_valid;
  data_t               o_r [N_ELEM];
  logic                o_sing, o_ovf;
  data_t               r_next [N_ELEM];
  logic                ovf_next;

  assign en      = !o_valid || rsp.ready;
  assign job_pop = en;

  // Stage 0: magnitudes and result signs.
  always_ff @(posedge clk) begin
    if (rst) begin
      b0_valid <= 1'b0;
    end else if (en) begin
      b0_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < N_ELEM; l++) begin
        b0_cmag[l] <= job.cof[l][COF_W-1] ? COF_W'(-job.cof[l]) : COF_W'(job.cof[l]);
        b0_neg[l]  <= job.cof[l][COF_W-1] != job.det[DET_W-1];
      end
      b0_dmag <= job.det[DET_W-1] ? DET_W'(-job.det) : DET_W'(job.det);
      b0_sing <= job.singular;
    end
  end

  // Stage 1: quotient of 2^32 or more saturates either way; flag it up front.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= b0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < N_ELEM; l++) begin
        rem[0][l] <= REM_W'(b0_cmag[l]) << (2 * FRAC_BITS);
        ovf[0][l] <= (REM_W'(b0_cmag[l]) << (2 * FRAC_BITS)) >= (REM_W'(b0_dmag) << QUO_W);
        quo[0][l] <= '0;
        neg[0][l] <= b0_neg[l];
      end
      dmag[0] <= b0_dmag;
      sing[0] <= b0_sing;
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar t = 1; t < NST; t++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[t] <= 1'b0;
      end else if (en) begin
        vld[t] <= vld[t-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < N_ELEM; l++) begin
          if (rem[t-1][l] >= (REM_W'(dmag[t-1]) << (QUO_W - t))) begin
            rem[t][l] <= rem[t-1][l] - (REM_W'(dmag[t-1]) << (QUO_W - t));
            quo[t][l] <= {quo[t-1][l][QUO_W-2:0], 1'b1};
          end else begin
            rem[t][l] <= rem[t-1][l];
            quo[t][l] <= {quo[t-1][l][QUO_W-2:0], 1'b0};
          end
          neg[t][l] <= neg[t-1][l];
          ovf[t][l] <= ovf[t-1][l];
        end
        dmag[t] <= dmag[t-1];
        sing[t] <= sing[t-1];
      end
    end
  end

  // Saturate and apply the sign; a singular matrix gives all zeros.
  always_comb begin
    ovf_next = 1'b0;
    for (int l = 0; l < N_ELEM; l++) begin
      if (sing[NST-1]) begin
        r_next[l] = '0;
      end else if (!neg[NST-1][l]) begin
        if (ovf[NST-1][l] || quo[NST-1][l][QUO_W-1]) begin
          r_next[l] = {1'b0, {(DATA_W-1){1'b1}}};
          ovf_next  = 1'b1;
        end else begin
          r_next[l] = quo[NST-1][l];
        end
      end else begin
        if (ovf[NST-1][l] || (quo[NST-1][l] > {1'b1, {(QUO_W-1){1'b0}}})) begin
          r_next[l] = {1'b1, {(DATA_W-1){1'b0}}};
          ovf_next  = 1'b1;
        end else begin
          r_next[l] = -quo[NST-1][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= vld[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_r    <= r_next;
      o_sing <= sing[NST-1];
      o_ovf  <= ovf_next;
    end
  end

  assign rsp.valid    = o_valid;
  assign rsp.r0       = o_r[0];
  assign rsp.r1       = o_r[1];
  assign rsp.r2       = o_r[2];
  assign rsp.r3       = o_r[3];
  assign rsp.r4       = o_r[4];
  assign rsp.r5       = o_r[5];
  assign rsp.r6       = o_r[6];
  assign rsp.r7       = o_r[7];
  assign rsp.r8       = o_r[8];
  assign rsp.singular = o_sing;
  assign rsp.overflow = o_ovf;

endmodule

FILE: rtl/matrix3x3_inverse_unit.sv
// Pipeline: 4 cofactor/determinant stages, the queue and 35 divider stages.
// Throughput: one matrix per cycle unless stalled; each of the nine dividers
//   retires one quotient bit per stage, so a new matrix enters every cycle.
// Reset: synchronous, active-high rst empties the pipelines and the queue;
//   payload registers are not cleared.
module matrix3x3_inverse_unit #(
  parameter int FRAC_BITS   = m3inv_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = m3inv_pkg::QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  m3i_in_if.sink  req,
  m3i_out_if.source rsp
);
  import m3inv_pkg::*;

  // Front: accept a matrix, form cofactors, determinant and the singular class.
  // Queue: decouple the front from divider back-pressure.
  // Back: nine pipelined restoring dividers, saturation and the output register.
  logic front_valid, queue_not_full;
  logic queue_not_empty, back_pop;
  job_t front_job, head_job;

  m3i_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .job_ready (queue_not_full),
    .job_valid (front_valid),
    .job       (front_job)
  );

  // Push only what the front holds; the front stalls itself when full.
  m3i_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_job  (front_job),
    .not_full  (queue_not_full),
    .pop       (back_pop),
    .not_empty (queue_not_empty),
    .head      (head_job)
  );

  // Advance the back whenever its output register is free or being taken.
  m3i_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (queue_not_empty),
    .job       (head_job),
    .job_pop   (back_pop),
    .rsp       (rsp)
  );

endmodule
